// ----- rtl/core/mprb_pkg.sv -----
// shared types and codes for the multi-port receive ring buffer
// used by every module in rtl/core except mprb_ram; depends on nothing else
package mprb_pkg;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned PORT_FIELD_W = 2;
    localparam int unsigned QUEUE_DEPTH  = 2;

    // request operation codes
    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_FLUSH = 2'd2
    } mode_t;

    // request payload
    typedef struct packed {
        logic [1:0]              mode;
        logic [PORT_FIELD_W-1:0] port;
        logic [BYTE_W-1:0]       rx_byte;
    } in_item_t;

    // response payload
    typedef struct packed {
        logic              pop_valid;
        logic [BYTE_W-1:0] pop_byte;
        logic              push_dropped;
    } out_item_t;

    // classified operation handed from front to back
    typedef struct packed {
        logic mem_wr;
        logic mem_rd;
        logic pop_valid;
        logic push_dropped;
    } op_flags_t;

endpackage

// ----- rtl/core/multi_port_rx_ring_buffer_unit.sv -----
// multi-port receive ring buffer: one byte ram split into a ring per port
// a request passes through the queue, then the ram access with its pending stage, then the response register
// throughput: one request per cycle while the queue has room, set by the single ram access slot in the back end
// reset clears all pointers, fill counts and handshake state, halt-when-full set to 1
// ram contents are not cleared; uses mprb_pkg, mprb_front, mprb_queue, mprb_back
module multi_port_rx_ring_buffer_unit #(
    parameter int unsigned RING_DEPTH = 64,
    parameter int unsigned PORT_COUNT = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    input  logic                req_valid,
    output logic                req_ready,
    input  mprb_pkg::in_item_t  req_item,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output mprb_pkg::out_item_t rsp_item
);

    localparam int unsigned ADDR_W = $clog2(PORT_COUNT * RING_DEPTH);

    logic                        q_push;
    logic                        q_pop;
    logic                        q_full;
    logic                        q_empty;
    mprb_pkg::op_flags_t         q_flags;
    logic [ADDR_W-1:0]           q_addr;
    logic [mprb_pkg::BYTE_W-1:0] q_byte;
    mprb_pkg::op_flags_t         head_flags;
    logic [ADDR_W-1:0]           head_addr;
    logic [mprb_pkg::BYTE_W-1:0] head_byte;

    // request intake and ring bookkeeping
    mprb_front #(
        .RING_DEPTH (RING_DEPTH),
        .PORT_COUNT (PORT_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_flags   (q_flags),
        .q_addr    (q_addr),
        .q_byte    (q_byte)
    );

    // decoupling queue
    mprb_queue #(
        .ADDR_W (ADDR_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_flags (q_flags),
        .push_addr  (q_addr),
        .push_byte  (q_byte),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head_flags (head_flags),
        .head_addr  (head_addr),
        .head_byte  (head_byte)
    );

    // ram access and response
    mprb_back #(
        .RING_DEPTH (RING_DEPTH),
        .PORT_COUNT (PORT_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .head_flags (head_flags),
        .head_addr  (head_addr),
        .head_byte  (head_byte),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_item   (rsp_item)
    );

    // a response with no byte carries a zero byte
    a_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_item.pop_valid |-> rsp_item.pop_byte == '0)
        else $error("pop_byte non-zero without pop_valid");

    // a pop result and a dropped push never come together
    a_excl_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_item.pop_valid && rsp_item.push_dropped))
        else $error("pop_valid and push_dropped both set");

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue overflow");

    // a taken request is waiting in the queue on the next cycle
    a_req_queued: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !q_empty)
        else $error("accepted request not queued");

endmodule

// ----- rtl/core/mprb_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module mprb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/mprb_front.sv -----
// front end: takes requests, keeps per-port pointers and fill counts, classifies ops
// uses mprb_pkg types and codes
module mprb_front #(
    parameter int unsigned RING_DEPTH = 64,
    parameter int unsigned PORT_COUNT = 4,
    localparam int unsigned ADDR_W    = $clog2(PORT_COUNT * RING_DEPTH)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  mprb_pkg::in_item_t                req_item,
    input  logic                              q_full,
    output logic                              q_push,
    output mprb_pkg::op_flags_t               q_flags,
    output logic [ADDR_W-1:0]                 q_addr,
    output logic [mprb_pkg::BYTE_W-1:0]       q_byte
);

    localparam int unsigned IDX_W  = $clog2(RING_DEPTH);
    localparam int unsigned CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int unsigned PORT_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int unsigned SLOTS  = 1 << PORT_W;

    logic                 halt_reg;
    logic [IDX_W-1:0]     wr_idx_reg  [SLOTS];
    logic [IDX_W-1:0]     wr_idx_next [SLOTS];
    logic [IDX_W-1:0]     rd_idx_reg  [SLOTS];
    logic [IDX_W-1:0]     rd_idx_next [SLOTS];
    logic [CNT_W-1:0]     fill_reg    [SLOTS];
    logic [CNT_W-1:0]     fill_next   [SLOTS];

    logic                 accept;
    logic                 in_range;
    logic [PORT_W-1:0]    sel;
    logic [IDX_W-1:0]     cur_w;
    logic [IDX_W-1:0]     cur_r;
    logic [CNT_W-1:0]     cur_f;
    logic [IDX_W-1:0]     w_inc;
    logic [IDX_W-1:0]     r_inc;
    logic                 ring_full;
    logic                 avail;
    logic [ADDR_W-1:0]    base;

    // handshakes
    assign cfg_ready = 1'b1;
    assign req_ready = !q_full;
    assign accept    = req_valid && req_ready;

    // port selection and current ring state
    assign sel      = PORT_W'({1'b0, req_item.port});
    assign in_range = 4'(req_item.port) < 4'(PORT_COUNT);
    assign cur_w    = wr_idx_reg[sel];
    assign cur_r    = rd_idx_reg[sel];
    assign cur_f    = fill_reg[sel];

    // pointer increments with wrap
    assign w_inc = (cur_w == IDX_W'(RING_DEPTH - 1)) ? '0 : cur_w + IDX_W'(1);
    assign r_inc = (cur_r == IDX_W'(RING_DEPTH - 1)) ? '0 : cur_r + IDX_W'(1);

    // availability depends on the overflow policy
    assign ring_full = (cur_f == CNT_W'(RING_DEPTH));
    assign avail     = halt_reg ? (cur_f != '0) : (cur_r != cur_w);

    // memory address of the selected ring slot
    assign base   = ADDR_W'(sel) * ADDR_W'(RING_DEPTH);
    assign q_addr = base + ADDR_W'(q_flags.mem_wr ? cur_w : cur_r);
    assign q_byte = req_item.rx_byte;
    assign q_push = accept;

    // classify the request and update pointers
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            wr_idx_next[i] = wr_idx_reg[i];
            rd_idx_next[i] = rd_idx_reg[i];
            fill_next[i]   = fill_reg[i];
        end
        q_flags = '0;
        if (accept && in_range)
        begin
            case (req_item.mode)
                mprb_pkg::MODE_PUSH:
                begin
                    if (halt_reg && ring_full)
                    begin
                        q_flags.push_dropped = 1'b1;
                    end
                    else
                    begin
                        q_flags.mem_wr   = 1'b1;
                        wr_idx_next[sel] = w_inc;
                        if (halt_reg)
                        begin
                            fill_next[sel] = cur_f + CNT_W'(1);
                        end
                    end
                end
                mprb_pkg::MODE_POP:
                begin
                    if (avail)
                    begin
                        q_flags.mem_rd    = 1'b1;
                        q_flags.pop_valid = 1'b1;
                        rd_idx_next[sel]  = r_inc;
                        if (halt_reg)
                        begin
                            fill_next[sel] = cur_f - CNT_W'(1);
                        end
                    end
                end
                mprb_pkg::MODE_FLUSH:
                begin
                    wr_idx_next[sel] = '0;
                    rd_idx_next[sel] = '0;
                    fill_next[sel]   = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // ring state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                wr_idx_reg[i] <= '0;
                rd_idx_reg[i] <= '0;
                fill_reg[i]   <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                wr_idx_reg[i] <= wr_idx_next[i];
                rd_idx_reg[i] <= rd_idx_next[i];
                fill_reg[i]   <= fill_next[i];
            end
        end
    end

    // overflow policy register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halt_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            halt_reg <= cfg_data;
        end
    end

endmodule

// ----- rtl/core/mprb_queue.sv -----
// two-entry queue of classified operations between front and back
// uses mprb_pkg for the flag struct and queue depth
module mprb_queue #(
    parameter int unsigned ADDR_W = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  mprb_pkg::op_flags_t         push_flags,
    input  logic [ADDR_W-1:0]           push_addr,
    input  logic [mprb_pkg::BYTE_W-1:0] push_byte,
    output logic                        full,
    input  logic                        pop,
    output logic                        empty,
    output mprb_pkg::op_flags_t         head_flags,
    output logic [ADDR_W-1:0]           head_addr,
    output logic [mprb_pkg::BYTE_W-1:0] head_byte
);

    mprb_pkg::op_flags_t         flags_reg [mprb_pkg::QUEUE_DEPTH];
    logic [ADDR_W-1:0]           addr_reg  [mprb_pkg::QUEUE_DEPTH];
    logic [mprb_pkg::BYTE_W-1:0] byte_reg  [mprb_pkg::QUEUE_DEPTH];
    logic                        wr_ptr_reg;
    logic                        wr_ptr_next;
    logic                        rd_ptr_reg;
    logic                        rd_ptr_next;
    logic [1:0]                  cnt_reg;
    logic [1:0]                  cnt_next;

    assign full  = (cnt_reg == 2'(mprb_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == 2'd0);

    assign head_flags = flags_reg[rd_ptr_reg];
    assign head_addr  = addr_reg[rd_ptr_reg];
    assign head_byte  = byte_reg[rd_ptr_reg];

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            flags_reg[wr_ptr_reg] <= push_flags;
            addr_reg[wr_ptr_reg]  <= push_addr;
            byte_reg[wr_ptr_reg]  <= push_byte;
        end
    end

endmodule

// ----- rtl/core/mprb_back.sv -----
// back end: executes queued ops on the byte ram and holds the response register
// uses mprb_pkg types and mprb_ram
module mprb_back #(
    parameter int unsigned RING_DEPTH = 64,
    parameter int unsigned PORT_COUNT = 4,
    localparam int unsigned ADDR_W    = $clog2(PORT_COUNT * RING_DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    output logic                        q_pop,
    input  mprb_pkg::op_flags_t         head_flags,
    input  logic [ADDR_W-1:0]           head_addr,
    input  logic [mprb_pkg::BYTE_W-1:0] head_byte,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output mprb_pkg::out_item_t         rsp_item
);

    logic                        p_valid_reg;
    logic                        p_valid_next;
    mprb_pkg::op_flags_t         p_flags_reg;
    mprb_pkg::op_flags_t         p_flags_next;
    logic                        rsp_valid_reg;
    logic                        rsp_valid_next;
    mprb_pkg::out_item_t         rsp_item_reg;
    mprb_pkg::out_item_t         rsp_item_next;

    logic                        out_free;
    logic                        load_out;
    logic                        issue;
    logic [mprb_pkg::BYTE_W-1:0] rdata;

    // issue one op when the pending stage can move on
    assign out_free = !rsp_valid_reg || rsp_ready;
    assign load_out = p_valid_reg && out_free;
    assign issue    = !q_empty && (!p_valid_reg || out_free);
    assign q_pop    = issue;

    // byte store
    mprb_ram #(
        .WIDTH (mprb_pkg::BYTE_W),
        .DEPTH (PORT_COUNT * RING_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (issue && head_flags.mem_wr),
        .waddr (head_addr),
        .wdata (head_byte),
        .re    (issue && head_flags.mem_rd),
        .raddr (head_addr),
        .rdata (rdata)
    );

    // pending stage and response register next values
    always_comb
    begin
        p_valid_next   = p_valid_reg;
        p_flags_next   = p_flags_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_item_next  = rsp_item_reg;
        if (issue)
        begin
            p_valid_next = 1'b1;
            p_flags_next = head_flags;
        end
        else if (load_out)
        begin
            p_valid_next = 1'b0;
        end
        if (load_out)
        begin
            rsp_valid_next              = 1'b1;
            rsp_item_next.pop_valid     = p_flags_reg.pop_valid;
            rsp_item_next.pop_byte      = p_flags_reg.mem_rd ? rdata : '0;
            rsp_item_next.push_dropped  = p_flags_reg.push_dropped;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg   <= p_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        p_flags_reg  <= p_flags_next;
        rsp_item_reg <= rsp_item_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

// ----- tb/sv/multi_port_rx_ring_buffer_unit_tb.sv -----
// self-checking bench for the multi-port receive ring buffer: push, pop, flush and reserved-code
// requests, each checked against a cycle-free prediction of the per-port rings
// depends on mprb_pkg and multi_port_rx_ring_buffer_unit
module multi_port_rx_ring_buffer_unit_tb;

    localparam int unsigned RING_DEPTH  = 64;
    localparam int unsigned PORT_COUNT  = 4;
    localparam int unsigned PTR_W       = $clog2(RING_DEPTH);
    localparam int unsigned FILL_W      = $clog2(RING_DEPTH + 1);
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned TAIL_CYCLES = 10;
    localparam int unsigned MAX_REPORTS = 10;

    // request code that the block must treat as a no-op
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    // receiver back-pressure styles
    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_MOSTLY,
        RDY_SPARSE,
        RDY_PERIODIC
    } rdy_style_t;

    // pending request with an optional hold until the ring buffer has drained
    typedef struct {
        bit                 hold_for_drain;
        mprb_pkg::in_item_t item;
    } ring_request_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_data  = 1'b1;
    logic                req_valid = 1'b0;
    logic                req_ready;
    mprb_pkg::in_item_t  req_item  = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    mprb_pkg::out_item_t rsp_item;

    // predicted ring state
    logic [7:0]        ring_mem [PORT_COUNT][RING_DEPTH];
    logic [PTR_W-1:0]  wr_ptr   [PORT_COUNT];
    logic [PTR_W-1:0]  rd_ptr   [PORT_COUNT];
    logic [FILL_W-1:0] fill_cnt [PORT_COUNT];
    logic              halt_mode;

    ring_request_t       ring_requests_q[$];
    mprb_pkg::out_item_t access_results_q[$];
    ring_request_t       next_req;

    bit           req_fire;
    int unsigned  burst_left = 1;
    int unsigned  gap_left   = 0;
    rdy_style_t   rdy_style  = RDY_ALWAYS;
    int unsigned  rdy_left   = 0;
    int unsigned  rdy_tick   = 0;

    int unsigned  cycle_count   = 0;
    int unsigned  err_count     = 0;
    int unsigned  reqs_taken    = 0;
    int unsigned  results_seen  = 0;
    int unsigned  bytes_popped  = 0;
    int unsigned  pushes_lost   = 0;
    int unsigned  drain_pauses  = 0;
    int unsigned  cfg_writes    = 0;

    multi_port_rx_ring_buffer_unit #(
        .RING_DEPTH (RING_DEPTH),
        .PORT_COUNT (PORT_COUNT)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

    always #1 clk = ~clk;

    // ring pointer advance with wrap
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] v);
        return (v == PTR_W'(RING_DEPTH - 1)) ? '0 : v + PTR_W'(1);
    endfunction

    // applies one request to the predicted rings and returns its response
    function automatic mprb_pkg::out_item_t ring_access_result(input mprb_pkg::in_item_t rq);
        mprb_pkg::out_item_t res;
        int unsigned         p;
        logic [PTR_W-1:0]    wp;
        logic [PTR_W-1:0]    rp;
        res = '0;
        p   = int'(rq.port);
        if (p < PORT_COUNT)
        begin
            wp = wr_ptr[p];
            rp = rd_ptr[p];
            case (rq.mode)
                mprb_pkg::MODE_PUSH:
                begin
                    if (halt_mode && fill_cnt[p] >= FILL_W'(RING_DEPTH))
                    begin
                        res.push_dropped = 1'b1;
                    end
                    else
                    begin
                        ring_mem[p][wp] = rq.rx_byte;
                        wr_ptr[p]       = ptr_inc(wp);
                        if (halt_mode)
                            fill_cnt[p] = fill_cnt[p] + FILL_W'(1);
                    end
                end
                mprb_pkg::MODE_POP:
                begin
                    // halt mode trusts the fill count, overwrite mode the pointers
                    if (halt_mode ? (fill_cnt[p] != '0) : (rp != wp))
                    begin
                        res.pop_valid = 1'b1;
                        res.pop_byte  = ring_mem[p][rp];
                        rd_ptr[p]     = ptr_inc(rp);
                        if (halt_mode)
                            fill_cnt[p] = fill_cnt[p] - FILL_W'(1);
                    end
                end
                mprb_pkg::MODE_FLUSH:
                begin
                    wr_ptr[p]   = '0;
                    rd_ptr[p]   = '0;
                    fill_cnt[p] = '0;
                end
                default: ;
            endcase
        end
        return res;
    endfunction

    task automatic add_request(input logic [1:0] md, input logic [1:0] prt,
                               input logic [7:0] data, input bit hold);
        ring_request_t r;
        r.hold_for_drain = hold;
        r.item.mode      = md;
        r.item.port      = prt;
        r.item.rx_byte   = data;
        ring_requests_q.push_back(r);
    endtask

    // random traffic: fill runs, drain runs, flushes, reserved-code noise and single requests
    task automatic queue_random_traffic(input int unsigned n_req);
        int unsigned made;
        int unsigned kind;
        int unsigned len;
        int unsigned hot;
        int unsigned i;
        logic [1:0]  prt;
        bit          hold;
        made = 0;
        hot  = $urandom_range(0, PORT_COUNT - 1);
        while (made < n_req)
        begin
            kind = (made == 0) ? 0 : $urandom_range(0, 19);
            prt  = ($urandom_range(0, 3) != 0) ? 2'(hot)
                                               : 2'($urandom_range(0, PORT_COUNT - 1));
            hold = (made == 0) || ($urandom_range(0, 15) == 0);
            if (kind < 4)
            begin
                // run close to the ring depth of 64, so it can fill or lap a ring
                len = $urandom_range(62, 70);
                for (i = 0; i < len; i++)
                    add_request(mprb_pkg::MODE_PUSH, prt, 8'($urandom), hold && i == 0);
                made += len;
            end
            else if (kind < 7)
            begin
                len = $urandom_range(8, 70);
                for (i = 0; i < len; i++)
                    add_request(mprb_pkg::MODE_POP, prt, 8'($urandom), hold && i == 0);
                made += len;
            end
            else if (kind == 7)
            begin
                add_request(mprb_pkg::MODE_FLUSH, prt, 8'($urandom), hold);
                made++;
            end
            else if (kind == 8)
            begin
                add_request(MODE_RESERVED, prt, 8'($urandom), hold);
                made++;
            end
            else if ($urandom_range(0, 9) < 4)
            begin
                add_request(mprb_pkg::MODE_PUSH, prt, 8'($urandom), hold);
                made++;
            end
            else
            begin
                add_request(mprb_pkg::MODE_POP, prt, 8'($urandom), hold);
                made++;
            end
        end
    endtask

    // waits until every request is taken and every response has come back
    task automatic wait_idle();
        @(posedge clk);
        while (ring_requests_q.size() != 0 || req_valid)
            @(posedge clk);
        while (access_results_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_halt_mode(input logic val);
        @(negedge clk);
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        halt_mode = val;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // request driver: bursts with random gaps, optional hold until drained
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_fire)
            begin
                // request still waiting to be taken
            end
            else if (gap_left != 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (ring_requests_q.size() == 0)
            begin
                req_valid <= 1'b0;
            end
            else if (ring_requests_q[0].hold_for_drain && access_results_q.size() != 0)
            begin
                req_valid <= 1'b0;
            end
            else
            begin
                next_req = ring_requests_q.pop_front();
                if (next_req.hold_for_drain)
                    drain_pauses++;
                req_item  <= next_req.item;
                req_valid <= 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                             : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // response back-pressure, switching to a randomly chosen style whenever its run counter runs out
    always @(negedge clk)
    begin
        if (rdy_left == 0)
        begin
            rdy_style = rdy_style_t'($urandom_range(0, 3));
            rdy_left  = $urandom_range(40, 200);
        end
        else
        begin
            rdy_left--;
        end
        case (rdy_style)
            RDY_ALWAYS: rsp_ready <= 1'b1;
            RDY_MOSTLY: rsp_ready <= ($urandom_range(0, 9) < 7);
            RDY_SPARSE: rsp_ready <= ($urandom_range(0, 9) < 2);
            default:    rsp_ready <= (rdy_tick % 3 == 0);
        endcase
        rdy_tick++;
    end

    // monitor: predict on each taken request, check each delivered response
    always @(posedge clk)
    begin
        mprb_pkg::out_item_t want;
        req_fire = rst_n && req_valid && req_ready;
        if (req_fire)
        begin
            want = ring_access_result(req_item);
            access_results_q.push_back(want);
            reqs_taken++;
            if (want.pop_valid)
                bytes_popped++;
            if (want.push_dropped)
                pushes_lost++;
        end
        if (rst_n && rsp_valid && rsp_ready)
        begin
            results_seen++;
            if (access_results_q.size() == 0)
            begin
                if (err_count < MAX_REPORTS)
                    $display("unexpected response: valid=%0b byte=%02h dropped=%0b",
                             rsp_item.pop_valid, rsp_item.pop_byte, rsp_item.push_dropped);
                err_count++;
            end
            else
            begin
                want = access_results_q.pop_front();
                if (rsp_item.pop_valid !== want.pop_valid
                    || rsp_item.pop_byte !== want.pop_byte
                    || rsp_item.push_dropped !== want.push_dropped)
                begin
                    if (err_count < MAX_REPORTS)
                    begin
                        $display("response %0d mismatch: expected valid=%0b byte=%02h dropped=%0b",
                                 results_seen, want.pop_valid, want.pop_byte,
                                 want.push_dropped);
                        $display("    got valid=%0b byte=%02h dropped=%0b",
                                 rsp_item.pop_valid, rsp_item.pop_byte, rsp_item.push_dropped);
                    end
                    err_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles with %0d responses outstanding",
                     cycle_count, access_results_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin
        halt_mode = 1'b1;
        for (int p = 0; p < PORT_COUNT; p++)
        begin
            wr_ptr[p]   = '0;
            rd_ptr[p]   = '0;
            fill_cnt[p] = '0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_halt_mode(1'b1);

        // directed: field extremes, empty pops, flush, reserved code
        add_request(mprb_pkg::MODE_PUSH,  2'd0, 8'h00, 1'b0);
        add_request(mprb_pkg::MODE_PUSH,  2'd0, 8'hFF, 1'b0);
        add_request(mprb_pkg::MODE_PUSH,  2'd3, 8'hA5, 1'b0);
        add_request(mprb_pkg::MODE_POP,   2'd0, 8'h00, 1'b0);
        add_request(mprb_pkg::MODE_POP,   2'd0, 8'h00, 1'b0);
        add_request(mprb_pkg::MODE_POP,   2'd0, 8'h00, 1'b0);
        add_request(mprb_pkg::MODE_POP,   2'd3, 8'h00, 1'b0);
        add_request(mprb_pkg::MODE_POP,   2'd3, 8'h00, 1'b0);
        add_request(mprb_pkg::MODE_PUSH,  2'd1, 8'h5A, 1'b0);
        add_request(mprb_pkg::MODE_PUSH,  2'd1, 8'h01, 1'b0);
        add_request(mprb_pkg::MODE_FLUSH, 2'd1, 8'hFF, 1'b0);
        add_request(mprb_pkg::MODE_POP,   2'd1, 8'h00, 1'b0);
        add_request(MODE_RESERVED,        2'd2, 8'hFF, 1'b0);
        add_request(mprb_pkg::MODE_PUSH,  2'd2, 8'h80, 1'b0);
        add_request(MODE_RESERVED,        2'd2, 8'h7F, 1'b0);
        add_request(mprb_pkg::MODE_POP,   2'd2, 8'h00, 1'b0);
        add_request(mprb_pkg::MODE_FLUSH, 2'd3, 8'h00, 1'b0);
        add_request(mprb_pkg::MODE_POP,   2'd2, 8'hFF, 1'b0);
        queue_random_traffic(90);
        wait_idle();

        // halt to overwrite without a flush: rings carry on from their halt-mode pointers
        write_halt_mode(1'b0);
        queue_random_traffic(90);
        wait_idle();

        // stale fill counts from overwrite mode would expose unwritten entries
        for (int p = 0; p < PORT_COUNT; p++)
            add_request(mprb_pkg::MODE_FLUSH, p[1:0], 8'($urandom), 1'b0);
        wait_idle();
        write_halt_mode(1'b1);
        queue_random_traffic(80);
        wait_idle();

        write_halt_mode(1'b0);
        queue_random_traffic(70);
        wait_idle();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (access_results_q.size() != 0)
        begin
            $display("%0d responses never arrived", access_results_q.size());
            err_count += access_results_q.size();
        end

        $display("%0d requests over %0d halt-mode writes, %0d responses checked, %0d errors",
                 reqs_taken, cfg_writes, results_seen, err_count);
        $display("%0d bytes popped, %0d pushes dropped on full rings, %0d drain pauses",
                 bytes_popped, pushes_lost, drain_pauses);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/mprb_pkg.sv
rtl/core/mprb_ram.sv
rtl/core/mprb_front.sv
rtl/core/mprb_queue.sv
rtl/core/mprb_back.sv
rtl/core/multi_port_rx_ring_buffer_unit.sv
tb/sv/multi_port_rx_ring_buffer_unit_tb.sv
